/* design/ste_pkg.sv */
`timescale 1ns / 1ps

package ste_pkg;

  // fixed field widths of the words
  localparam int CMD_W   = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 10;
  localparam int STAT_W  = 2;
  localparam int FIDX_W  = 11;
  localparam int CNT_W   = 11;
  localparam int IDX_W   = 10;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INS_UNIQUE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_DUP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_VALUE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_POS    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd3;

  // index reported when there is no hit
  localparam logic [FIDX_W-1:0] NO_HIT = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SRCH,
    ST_EXEC
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT
  } cell_op_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } srch_res_t;

endpackage

/* design/ste_cell.sv */
`timescale 1ns / 1ps

module ste_cell (
  input  logic                              clk,
  input  ste_pkg::cell_op_t                 op,
  input  logic                              flag_en,
  input  logic signed [ste_pkg::VAL_W-1:0]  key,
  input  logic signed [ste_pkg::VAL_W-1:0]  left_entry,
  input  logic signed [ste_pkg::VAL_W-1:0]  right_entry,
  output logic signed [ste_pkg::VAL_W-1:0]  entry,
  output logic                              lt,
  output logic                              gt
);

  // entry update: hold, take the key, or shift from a neighbor
  always_ff @(posedge clk) begin
    unique case (op)
      ste_pkg::CELL_HOLD:  entry <= entry;
      ste_pkg::CELL_LOAD:  entry <= key;
      ste_pkg::CELL_LEFT:  entry <= left_entry;
      ste_pkg::CELL_RIGHT: entry <= right_entry;
      default:             entry <= entry;
    endcase
  end

  // signed compare of the key against the held entry
  always_ff @(posedge clk) begin
    if (flag_en) begin
      lt <= key < entry;
      gt <= key > entry;
    end
  end

endmodule

/* design/ste_search.sv */
`timescale 1ns / 1ps

module ste_search #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [$clog2(CAPACITY+1)-1:0]       count,
  input  logic [CAPACITY-1:0]                 lt_vec,
  input  logic [CAPACITY-1:0]                 gt_vec,
  output ste_pkg::srch_res_t                  res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic              busy;
  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] diff;
  logic signed [SW-1:0] mid;
  logic [AW-1:0]     mid_ix;

  // low-biased midpoint of the live range
  assign diff   = hi - lo;
  assign mid    = lo + (diff >>> 1);
  assign mid_ix = mid[AW-1:0];

  // one probe per cycle against the registered cell flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      res  <= '0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        lo   <= '0;
        hi   <= $signed({1'b0, count}) - SW'(1);
      end else if (busy) begin
        if (lo > hi) begin
          busy     <= 1'b0;
          res.done <= 1'b1;
          res.hit  <= 1'b0;
        end else if (lt_vec[mid_ix]) begin
          hi <= mid - SW'(1);
        end else if (gt_vec[mid_ix]) begin
          lo <= mid + SW'(1);
        end else begin
          busy     <= 1'b0;
          res.done <= 1'b1;
          res.hit  <= 1'b1;
          res.idx  <= ste_pkg::IDX_W'(mid_ix);
        end
      end
    end
  end

endmodule

/* design/sorted_table_engine_unit.sv */
`timescale 1ns / 1ps

// channel | handshake           | payload
// in      | in_valid / in_stall   | command, value, position
// out     | out_valid / out_stall | status, found_index, entry_count
//
// insert, delete by position, clear and unused codes: the word passes the compare
// state, where the cells register their flags, then the execute state, where the
// cells shift and the result is registered; the next word is taken after that.
// search and delete by value add a search state between compare and execute,
// one probe a cycle, until a hit or an empty range hands back the outcome.
// rst is synchronous and empties the table; entries need no clearing.
// in_stall is high while a word is in work; a stalled result holds in the
// output register and a new word is still taken behind it.

module sorted_table_engine_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ste_pkg::CMD_W-1:0]           command,
  input  logic signed [ste_pkg::VAL_W-1:0]    value,
  input  logic [ste_pkg::POS_W-1:0]           position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ste_pkg::STAT_W-1:0]          status,
  output logic signed [ste_pkg::FIDX_W-1:0]   found_index,
  output logic [ste_pkg::CNT_W-1:0]           entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  ste_pkg::state_t    state;
  ste_pkg::state_t    state_next;
  ste_pkg::srch_res_t srch;

  logic [ste_pkg::CMD_W-1:0]        cmd_q;
  logic signed [ste_pkg::VAL_W-1:0] value_q;
  logic [ste_pkg::POS_W-1:0]        pos_q;
  logic                             srch_hit;
  logic [ste_pkg::IDX_W-1:0]        srch_idx;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    count_next;

  logic signed [ste_pkg::VAL_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]              lt_vec;
  logic [CAPACITY-1:0]              gt_vec;
  logic [CAPACITY-1:0]              vld;
  logic [CAPACITY-1:0]              keep;
  logic [CAPACITY-1:0]              prev_keep;
  ste_pkg::cell_op_t                cell_op [CAPACITY];

  logic                             accept;
  logic                             out_free;
  logic                             apply;
  logic                             srch_start;
  logic                             full;
  logic                             dup;
  logic                             ins_go;
  logic                             del_go;
  logic [ste_pkg::IDX_W-1:0]        del_k;
  logic [ste_pkg::STAT_W-1:0]       stat_next;
  logic [ste_pkg::FIDX_W-1:0]       fidx_next;

  assign in_stall   = (state != ste_pkg::ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign apply      = (state == ste_pkg::ST_EXEC) && out_free;
  assign srch_start = (state == ste_pkg::ST_CMP) &&
                      (cmd_q == ste_pkg::CMD_SEARCH || cmd_q == ste_pkg::CMD_DEL_VALUE);

  // row of cells, each passing its entry to both neighbors
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [ste_pkg::VAL_W-1:0] left_e;
    logic signed [ste_pkg::VAL_W-1:0] right_e;

    if (j == 0) begin : g_first
      assign left_e       = value_q;
      assign prev_keep[j] = 1'b1;
    end else begin : g_mid
      assign left_e       = entries[j-1];
      assign prev_keep[j] = keep[j-1];
    end

    if (j == CAPACITY - 1) begin : g_last
      assign right_e = entries[j];
    end else begin : g_inner
      assign right_e = entries[j+1];
    end

    assign vld[j]  = CW'(j) < count;
    // entry stays in place on insert when it sorts before the new value
    assign keep[j] = vld[j] && ((cmd_q == ste_pkg::CMD_INS_UNIQUE) ? gt_vec[j] : !lt_vec[j]);

    // per-cell shift control
    always_comb begin
      cell_op[j] = ste_pkg::CELL_HOLD;
      if (apply && ins_go) begin
        if (keep[j]) begin
          cell_op[j] = ste_pkg::CELL_HOLD;
        end else if (prev_keep[j]) begin
          cell_op[j] = ste_pkg::CELL_LOAD;
        end else begin
          cell_op[j] = ste_pkg::CELL_LEFT;
        end
      end else if (apply && del_go && (ste_pkg::IDX_W'(j) >= del_k)) begin
        cell_op[j] = ste_pkg::CELL_RIGHT;
      end
    end

    ste_cell u_cell (
      .clk         (clk),
      .op          (cell_op[j]),
      .flag_en     (state == ste_pkg::ST_CMP),
      .key         (value_q),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (entries[j]),
      .lt          (lt_vec[j]),
      .gt          (gt_vec[j])
    );
  end

  // binary search over the registered compare flags
  ste_search #(
    .CAPACITY (CAPACITY)
  ) u_search (
    .clk    (clk),
    .rst    (rst),
    .start  (srch_start),
    .count  (count),
    .lt_vec (lt_vec),
    .gt_vec (gt_vec),
    .res    (srch)
  );

  // command decode and result
  assign full = (count == CW'(CAPACITY));
  assign dup  = |(vld & ~lt_vec & ~gt_vec);

  always_comb begin
    stat_next  = ste_pkg::STAT_OK;
    fidx_next  = ste_pkg::NO_HIT;
    count_next = count;
    ins_go     = 1'b0;
    del_go     = 1'b0;
    del_k      = pos_q;
    unique case (cmd_q)
      ste_pkg::CMD_INS_UNIQUE, ste_pkg::CMD_INS_DUP: begin
        if (full) begin
          stat_next = ste_pkg::STAT_FULL;
        end else if (cmd_q == ste_pkg::CMD_INS_UNIQUE && dup) begin
          stat_next = ste_pkg::STAT_DUP;
        end else begin
          ins_go     = 1'b1;
          count_next = count + CW'(1);
        end
      end
      ste_pkg::CMD_SEARCH: begin
        if (srch_hit) begin
          fidx_next = ste_pkg::FIDX_W'(srch_idx);
        end else begin
          stat_next = ste_pkg::STAT_MISS;
        end
      end
      ste_pkg::CMD_DEL_VALUE: begin
        if (srch_hit) begin
          fidx_next  = ste_pkg::FIDX_W'(srch_idx);
          del_go     = 1'b1;
          del_k      = srch_idx;
          count_next = count - CW'(1);
        end else begin
          stat_next = ste_pkg::STAT_MISS;
        end
      end
      ste_pkg::CMD_DEL_POS: begin
        if (ste_pkg::CNT_W'(pos_q) >= ste_pkg::CNT_W'(count)) begin
          stat_next = ste_pkg::STAT_MISS;
        end else begin
          del_go     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      ste_pkg::CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ste_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ste_pkg::ST_IDLE: begin
        if (accept) state_next = ste_pkg::ST_CMP;
      end
      ste_pkg::ST_CMP: begin
        state_next = srch_start ? ste_pkg::ST_SRCH : ste_pkg::ST_EXEC;
      end
      ste_pkg::ST_SRCH: begin
        if (srch.done) state_next = ste_pkg::ST_EXEC;
      end
      ste_pkg::ST_EXEC: begin
        if (out_free) state_next = ste_pkg::ST_IDLE;
      end
      default: state_next = ste_pkg::ST_IDLE;
    endcase
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= command;
      value_q <= value;
      pos_q   <= position;
    end
  end

  // search outcome capture; hit flag cleared when a search starts
  always_ff @(posedge clk) begin
    if (srch_start) begin
      srch_hit <= 1'b0;
    end else if (srch.done) begin
      srch_hit <= srch.hit;
      srch_idx <= srch.idx;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      status      <= stat_next;
      found_index <= fidx_next;
      entry_count <= ste_pkg::CNT_W'(count_next);
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ste_pkg::CNT_W'(count) <= ste_pkg::CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    apply |=> (state == ste_pkg::ST_IDLE) && out_valid)
    else $error("result not posted after execute");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    apply && (cmd_q == ste_pkg::CMD_CLEAR) |=> (count == '0))
    else $error("clear left entries");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    srch.done && srch.hit |-> ste_pkg::CNT_W'(srch.idx) < ste_pkg::CNT_W'(count))
    else $error("search hit beyond stored entries");
`endif

endmodule

/* dv/ste_checker.sv */
`timescale 1ns / 1ps

module ste_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [ste_pkg::CMD_W-1:0]         command,
  input  logic signed [ste_pkg::VAL_W-1:0]  value,
  input  logic [ste_pkg::POS_W-1:0]         position,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [ste_pkg::STAT_W-1:0]        status,
  input  logic signed [ste_pkg::FIDX_W-1:0] found_index,
  input  logic [ste_pkg::CNT_W-1:0]         entry_count,
  output int                                fail_count,
  output int                                pending
);

  typedef struct packed {
    logic [ste_pkg::STAT_W-1:0] status;
    logic [ste_pkg::FIDX_W-1:0] found_index;
    logic [ste_pkg::CNT_W-1:0]  entry_count;
  } table_result_t;

  // shadow copy of the sorted table
  logic signed [ste_pkg::VAL_W-1:0] shadow_entries [CAPACITY];
  int                               shadow_count = 0;
  table_result_t                    expected_results [$];
  int                               errors = 0;

  // binary search, low-biased midpoint, first probe that hits
  function automatic int probe_search(logic signed [ste_pkg::VAL_W-1:0] v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_count - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (v < shadow_entries[mid]) hi = mid - 1;
      else if (v > shadow_entries[mid]) lo = mid + 1;
      else return mid;
    end
    return -1;
  endfunction

  // close the gap left by a removed entry
  function automatic void drop_entry(int at);
    int j;
    for (j = at + 1; j < shadow_count; j++) shadow_entries[j-1] = shadow_entries[j];
    shadow_count--;
  endfunction

  // run one command word on the shadow table and build its result word
  function automatic table_result_t apply_command(logic [ste_pkg::CMD_W-1:0] cmd,
                                                  logic signed [ste_pkg::VAL_W-1:0] v,
                                                  logic [ste_pkg::POS_W-1:0] p);
    table_result_t r;
    int            i;
    int            j;
    int            hit;
    r.status      = ste_pkg::STAT_OK;
    r.found_index = ste_pkg::NO_HIT;
    case (cmd)
      ste_pkg::CMD_INS_UNIQUE, ste_pkg::CMD_INS_DUP: begin
        // a full table wins over the duplicate check
        if (shadow_count >= CAPACITY) begin
          r.status = ste_pkg::STAT_FULL;
        end else begin
          i = 0;
          if (cmd == ste_pkg::CMD_INS_UNIQUE) begin
            while (i < shadow_count && v > shadow_entries[i]) i++;
          end else begin
            while (i < shadow_count && v >= shadow_entries[i]) i++;
          end
          if (cmd == ste_pkg::CMD_INS_UNIQUE && i < shadow_count &&
              v == shadow_entries[i]) begin
            r.status = ste_pkg::STAT_DUP;
          end else begin
            for (j = shadow_count; j > i; j--) shadow_entries[j] = shadow_entries[j-1];
            shadow_entries[i] = v;
            shadow_count++;
          end
        end
      end
      ste_pkg::CMD_SEARCH: begin
        hit = probe_search(v);
        if (hit < 0) r.status = ste_pkg::STAT_MISS;
        else r.found_index = hit[ste_pkg::FIDX_W-1:0];
      end
      ste_pkg::CMD_DEL_VALUE: begin
        hit = probe_search(v);
        if (hit < 0) begin
          r.status = ste_pkg::STAT_MISS;
        end else begin
          r.found_index = hit[ste_pkg::FIDX_W-1:0];
          drop_entry(hit);
        end
      end
      ste_pkg::CMD_DEL_POS: begin
        if (int'(p) >= shadow_count) r.status = ste_pkg::STAT_MISS;
        else drop_entry(int'(p));
      end
      ste_pkg::CMD_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    r.entry_count = shadow_count[ste_pkg::CNT_W-1:0];
    return r;
  endfunction

  // predict on accepted command words, compare accepted result words
  always @(posedge clk) begin : watch
    table_result_t want;
    if (rst) begin
      expected_results.delete();
      shadow_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_command(command, value, position));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, got %0d %0d %0d",
                   $time, status, found_index, entry_count);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
          end
          if (found_index !== want.found_index) begin
            errors++;
            $display("%0t: found_index expected %0d, got %0d", $time,
                     $signed(want.found_index), found_index);
          end
          if (entry_count !== want.entry_count) begin
            errors++;
            $display("%0t: entry_count expected %0d, got %0d", $time,
                     want.entry_count, entry_count);
          end
        end
      end
    end
    pending    <= expected_results.size();
    fail_count <= errors;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int CAP = 64;

  // codes the block leaves unused
  localparam logic [ste_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [ste_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [ste_pkg::VAL_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [ste_pkg::VAL_W-1:0] V_MAX = 32'sh7fff_ffff;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_stall;
  logic [ste_pkg::CMD_W-1:0]          command;
  logic signed [ste_pkg::VAL_W-1:0]   value;
  logic [ste_pkg::POS_W-1:0]          position;
  logic                               out_valid;
  logic                               out_stall;
  logic [ste_pkg::STAT_W-1:0]         status;
  logic signed [ste_pkg::FIDX_W-1:0]  found_index;
  logic [ste_pkg::CNT_W-1:0]          entry_count;
  int                                 fail_count;
  int                                 pending;

  bit                                 gaps_on = 1'b1;
  bit                                 hold_go = 1'b0;
  bit                                 hold_done = 1'b0;
  logic signed [ste_pkg::VAL_W-1:0]   recent_values [$];

  sorted_table_engine_unit #(.CAPACITY(CAP)) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .value       (value),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_index (found_index),
    .entry_count (entry_count)
  );

  ste_checker #(.CAPACITY(CAP)) chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .value       (value),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_index (found_index),
    .entry_count (entry_count),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("sorted_table_engine_unit regression: fail");
    $finish;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int gap_len();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // values clustered for hits and duplicates, plus extremes and noise
  function automatic logic signed [ste_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, 16) - 8;
    if (r < 60 && recent_values.size() > 0)
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    if (r < 72) begin
      case ($urandom_range(0, 5))
        0: return V_MIN;
        1: return V_MAX;
        2: return V_MIN + 1;
        3: return V_MAX - 1;
        4: return -1;
        default: return 0;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [ste_pkg::POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 75) return ste_pkg::POS_W'($urandom_range(0, CAP + 6));
    return ste_pkg::POS_W'($urandom_range(0, 1023));
  endfunction

  // offer one command word and hold it until taken
  task automatic send_word(logic [ste_pkg::CMD_W-1:0] c,
                           logic signed [ste_pkg::VAL_W-1:0] v,
                           logic [ste_pkg::POS_W-1:0] p);
    int gap;
    command  <= c;
    value    <= v;
    position <= p;
    in_valid <= 1'b1;
    if (c == ste_pkg::CMD_INS_UNIQUE || c == ste_pkg::CMD_INS_DUP) begin
      recent_values.push_back(v);
      if (recent_values.size() > 24) void'(recent_values.pop_front());
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // random mix of all commands
  task automatic mixed_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) send_word(ste_pkg::CMD_INS_UNIQUE, pick_value(), pick_position());
    else if (r < 48) send_word(ste_pkg::CMD_INS_DUP, pick_value(), pick_position());
    else if (r < 66) send_word(ste_pkg::CMD_SEARCH, pick_value(), pick_position());
    else if (r < 79) send_word(ste_pkg::CMD_DEL_VALUE, pick_value(), pick_position());
    else if (r < 92) send_word(ste_pkg::CMD_DEL_POS, pick_value(), pick_position());
    else if (r < 94) send_word(ste_pkg::CMD_CLEAR, pick_value(), pick_position());
    else if (r < 97) send_word(CMD_SPARE_6, pick_value(), pick_position());
    else send_word(CMD_SPARE_7, pick_value(), pick_position());
  endtask

  // clear, fill past capacity, then poke the full table
  task automatic fill_sequence();
    int n;
    int r;
    send_word(ste_pkg::CMD_CLEAR, pick_value(), pick_position());
    n = CAP + 16;
    repeat (n) begin
      if ($urandom_range(0, 99) < 85)
        send_word(ste_pkg::CMD_INS_DUP, pick_value(), pick_position());
      else
        send_word(ste_pkg::CMD_INS_UNIQUE, pick_value(), pick_position());
    end
    repeat (12) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_word(ste_pkg::CMD_INS_UNIQUE, pick_value(), pick_position());
      else if (r < 55) send_word(ste_pkg::CMD_INS_DUP, pick_value(), pick_position());
      else if (r < 80) send_word(ste_pkg::CMD_SEARCH, pick_value(), pick_position());
      else if (r < 90) send_word(ste_pkg::CMD_DEL_VALUE, pick_value(), pick_position());
      else send_word(ste_pkg::CMD_DEL_POS, pick_value(), pick_position());
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // command stimulus and verdict
  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    command  <= ste_pkg::CMD_INS_UNIQUE;
    value    <= '0;
    position <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, misses, bad positions
    send_word(ste_pkg::CMD_SEARCH, 0, 0);
    send_word(ste_pkg::CMD_DEL_VALUE, 0, 0);
    send_word(ste_pkg::CMD_DEL_POS, 0, 0);
    send_word(ste_pkg::CMD_INS_UNIQUE, V_MIN, 0);
    send_word(ste_pkg::CMD_INS_UNIQUE, V_MAX, 0);
    send_word(ste_pkg::CMD_INS_UNIQUE, 0, 0);
    send_word(ste_pkg::CMD_INS_UNIQUE, 0, 0);
    send_word(ste_pkg::CMD_INS_DUP, 0, 10'h3ff);
    send_word(ste_pkg::CMD_INS_DUP, -1, 0);
    send_word(ste_pkg::CMD_INS_DUP, V_MAX, 0);
    send_word(ste_pkg::CMD_SEARCH, 0, 0);
    send_word(ste_pkg::CMD_SEARCH, V_MIN, 0);
    send_word(ste_pkg::CMD_SEARCH, V_MAX, 0);
    send_word(ste_pkg::CMD_SEARCH, 5, 0);
    send_word(ste_pkg::CMD_DEL_VALUE, V_MAX, 0);
    send_word(ste_pkg::CMD_DEL_VALUE, 7, 0);
    send_word(ste_pkg::CMD_DEL_POS, V_MAX, 10'h3ff);
    send_word(ste_pkg::CMD_DEL_POS, 0, 5);
    send_word(ste_pkg::CMD_DEL_POS, 0, 4);
    send_word(CMD_SPARE_6, V_MAX, 10'h3ff);
    send_word(CMD_SPARE_7, V_MIN, 10'h2aa);
    send_word(ste_pkg::CMD_CLEAR, -1, 10'h155);
    send_word(ste_pkg::CMD_SEARCH, V_MIN, 0);

    // random phases, alternating table fills and mixed traffic
    for (int phase = 0; phase < 8; phase++) begin
      gaps_on = (phase % 4 != 1);
      if (phase == 2) hold_go = 1'b1;
      if (phase % 2 == 0) begin
        fill_sequence();
      end else begin
        repeat (165) mixed_word();
      end
      if (phase == 3) wait_drain();
    end

    wait_drain();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("sorted_table_engine_unit regression: pass");
    end else begin
      $display("sorted_table_engine_unit regression: fail");
    end
    $finish;
  end

endmodule
